// ----- hdl/ctbl_pkg.sv -----
`default_nettype none
package ctbl_pkg;
  localparam int MaxRows = 16;
  localparam int MaxCols = 16;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int AddrW = RowW + ColW;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [0:0] CFG_ROWS = 1'b0;
  localparam logic [0:0] CFG_COLS = 1'b1;

  function automatic logic [4:0] clamp_count(input logic [4:0] r, input logic [4:0] lim);
    logic [4:0] v;
    begin
      v = r;
      if (r == 5'd0) v = 5'd1;
      else if (r > lim) v = lim;
      return v;
    end
  endfunction
endpackage
`default_nettype wire

// ----- hdl/calibration_table_bilinear_lookup.sv -----
`default_nettype none
// channel  | signals                                          | dir
// in       | in_valid/in_ready, operation..z_value            | in
// out      | out_valid/out_ready, interpolated_value          | out
// cfg      | cfg_write, cfg_index, cfg_data                   | in
// A write completes in the cycle it is accepted. A query runs a row key scan
// at one key per cycle, a column scan in which each key passes a registered
// memory read, and up to three blends in one shared unit (33-step shift-add
// multiply, 66-step restoring divide).
// rst is synchronous and clears control state; table contents are undefined.
// in_ready is low from query acceptance until its result is taken.
module calibration_table_bilinear_lookup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [3:0]  row_index,
  input  wire logic [3:0]  column_index,
  input  wire logic signed [31:0] x_value,
  input  wire logic signed [31:0] y_value,
  input  wire logic signed [31:0] z_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] interpolated_value,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import ctbl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_RSCAN = 4'd1, S_RROW = 4'd2,
    S_CREQ = 4'd3, S_CWAIT = 4'd4, S_CCHK = 4'd5, S_BLEND = 4'd6,
    S_DIV = 4'd7, S_BDONE = 4'd8, S_OUT = 4'd9, S_RWAIT = 4'd10,
    S_MUL = 4'd11;

  logic [3:0] state;
  logic [4:0] rows_in_use, columns_in_use;
  logic signed [31:0] row_keys [MaxRows];
  logic signed [31:0] column_keys [MaxRows*MaxCols];
  logic signed [31:0] cell_values [MaxRows*MaxCols];

  logic signed [31:0] qx, qy;
  logic [4:0] nr, nc;
  logic [RowW-1:0] rlo, rhi, rcur;
  logic two_rows, second;
  logic signed [33:0] rdlo, rdhi;
  logic [4:0] ri;
  logic [4:0] ci;
  logic [AddrW-1:0] raddr;
  logic signed [31:0] rk, rv;
  logic signed [31:0] pk, pv;
  logic signed [31:0] vrow0;
  logic [1:0] cphase;
  // blend unit
  logic signed [33:0] bvlo, bvhi, bdlo, bdhi;
  logic [1:0] bwhich;
  logic [65:0] prod;
  logic [32:0] mcand, mplier;
  logic [33:0] den, rem;
  logic [65:0] quo;
  logic [6:0] bit_cnt;
  logic neg;
  logic signed [33:0] bres;
  logic signed [31:0] res;

  always_ff @(posedge clk) begin
    rk <= column_keys[raddr];
    rv <= cell_values[raddr];
    if (state == S_IDLE && in_valid && operation == OP_WRITE) begin
      row_keys[row_index] <= x_value;
      column_keys[{row_index, column_index}] <= y_value;
      cell_values[{row_index, column_index}] <= z_value;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign interpolated_value = res;

  logic signed [33:0] gap;
  always_comb gap = bvhi - bvlo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rows_in_use <= 5'd1;
      columns_in_use <= 5'd1;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_ROWS) rows_in_use <= cfg_data;
        else columns_in_use <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && operation == OP_QUERY) begin
            qx <= x_value; qy <= y_value;
            nr <= clamp_count(rows_in_use, 5'(MaxRows));
            nc <= clamp_count(columns_in_use, 5'(MaxCols));
            ri <= 5'd1;
            bwhich <= 2'd0;
            state <= S_RSCAN;
          end
        end
        S_RSCAN: begin
          // one row key compared per cycle
          if ($signed(qx) >= row_keys[RowW'(nr - 5'd1)]) begin
            rlo <= RowW'(nr - 5'd1); two_rows <= 1'b0; state <= S_RROW;
          end else if ($signed(qx) <= row_keys[0]) begin
            rlo <= '0; two_rows <= 1'b0; state <= S_RROW;
          end else if (ri >= nr - 5'd1 || row_keys[RowW'(ri)] >= qx) begin
            rlo <= RowW'(ri - 5'd1); rhi <= RowW'(ri); two_rows <= 1'b1;
            rdlo <= 34'(qx) - 34'(row_keys[RowW'(ri - 5'd1)]);
            rdhi <= 34'(row_keys[RowW'(ri)]) - 34'(qx);
            state <= S_RROW;
          end else ri <= ri + 5'd1;
          second <= 1'b0;
        end
        S_RROW: begin
          rcur <= second ? rhi : rlo;
          ci <= 5'd0; cphase <= 2'd0;
          state <= S_CREQ;
        end
        S_CREQ: begin
          raddr <= {rcur, ColW'(cphase == 2'd0 ? nc - 5'd1 : (cphase == 2'd1 ? 5'd0 : ci))};
          state <= S_RWAIT;
        end
        S_RWAIT: state <= S_CWAIT;
        S_CWAIT: begin
          if (cphase == 2'd0) begin
            if (qy >= rk) begin bres <= 34'(rv); state <= S_BDONE; end
            else begin cphase <= 2'd1; state <= S_CREQ; end
          end else if (cphase == 2'd1) begin
            if (qy <= rk) begin bres <= 34'(rv); state <= S_BDONE; end
            else begin
              pk <= rk; pv <= rv; ci <= 5'd1; cphase <= 2'd2;
              state <= S_CREQ;
            end
          end else state <= S_CCHK;
        end
        S_CCHK: begin
          if (ci >= nc - 5'd1 || rk >= qy) begin
            bvlo <= 34'(pv); bvhi <= 34'(rv);
            bdlo <= 34'(qy) - 34'(pk); bdhi <= 34'(rk) - 34'(qy);
            bwhich <= 2'd0; state <= S_BLEND;
          end else begin
            pk <= rk; pv <= rv;
            ci <= ci + 5'd1; state <= S_CREQ;
          end
        end
        S_BLEND: begin
          if (bdlo <= 0) begin bres <= bvlo; state <= S_BDONE; end
          else if (bdhi <= 0) begin bres <= bvhi; state <= S_BDONE; end
          else begin
            neg <= gap < 0;
            mcand <= 33'(gap < 0 ? -gap : gap);
            mplier <= bdlo[32:0];
            prod <= '0;
            den <= 34'(bdlo + bdhi);
            bit_cnt <= 7'd33;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // shift-add multiply, one multiplier bit per cycle
          if (bit_cnt == 7'd0) begin
            rem <= '0; bit_cnt <= 7'd66;
            state <= S_DIV;
          end else begin
            prod <= {prod[64:0], 1'b0} + (mplier[32] ? 66'(mcand) : 66'd0);
            mplier <= {mplier[31:0], 1'b0};
            bit_cnt <= bit_cnt - 7'd1;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (bit_cnt == 7'd0) begin
            bres <= neg ? bvlo - $signed(quo[33:0]) : bvlo + $signed(quo[33:0]);
            state <= S_BDONE;
          end else begin
            if ({rem[32:0], prod[65]} >= den) begin
              rem <= {rem[32:0], prod[65]} - den;
              quo <= {quo[64:0], 1'b1};
            end else begin
              rem <= {rem[32:0], prod[65]};
              quo <= {quo[64:0], 1'b0};
            end
            prod <= {prod[64:0], 1'b0};
            bit_cnt <= bit_cnt - 7'd1;
          end
        end
        S_BDONE: begin
          if (bwhich == 2'd2 || (!two_rows)) begin
            res <= bres[31:0]; state <= S_OUT;
          end else if (!second) begin
            vrow0 <= bres[31:0]; second <= 1'b1; state <= S_RROW;
          end else begin
            bvlo <= 34'(vrow0); bvhi <= bres; bdlo <= rdlo; bdhi <= rdhi;
            bwhich <= 2'd2; state <= S_BLEND;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(interpolated_value))
    else $error("result dropped");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != 34'd0) else $error("zero divisor");
endmodule
`default_nettype wire
